[src/binary_to_ascii_hex_dec_macros.svh]
// Assertion macros shared by the binary to ASCII converter.
// Included by the top level; needs nothing else.
`ifndef BINARY_TO_ASCII_HEX_DEC_MACROS_SVH
`define BINARY_TO_ASCII_HEX_DEC_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B2A_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B2A_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/b2a_pkg.sv]
// Package for the binary to ASCII converter: radix codes, controller states,
// command and status structs, and the digit to ASCII mapping. No dependencies.
`default_nettype none

package b2a_pkg;

  // Widths of the stream fields.
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned CharWidth   = 7;
  localparam int unsigned DecDigits   = 10;
  localparam int unsigned HexDigits   = 8;
  localparam int unsigned DigitRegW   = 4 * DecDigits;
  localparam int unsigned StepCountW  = $clog2(ValueWidth);
  localparam int unsigned RemainW     = $clog2(DecDigits + 1);

  // Radix select carried on the input tuser.
  localparam logic CMD_HEX = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  localparam logic [CharWidth-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CharWidth-1:0] ASCII_UPPER_A = 7'h41;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } b2a_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic dabble;
    logic skip;
    logic emit;
  } b2a_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;
    logic lead_zero;
    logic last_digit;
    logic out_free;
  } b2a_status_t;

  // Map a digit 0..15 to '0'..'9' or 'A'..'F'.
  function automatic logic [CharWidth-1:0] digit_to_ascii(input logic [3:0] d);
    logic [CharWidth-1:0] base;
    if (d < 4'd10) begin
      base = ASCII_ZERO;
    end else begin
      base = ASCII_UPPER_A - 7'd10;
    end
    return base + {3'b000, d};
  endfunction

endpackage

`default_nettype wire

[src/binary_to_ascii_hex_dec.sv]
// Top level of the binary to ASCII converter (hex or decimal digits).
// Depends on b2a_pkg, b2a_ctrl, b2a_datapath and the assertion macro header.
//
// Channel   Dir  Signals                      Contents
// input     in   s_tvalid s_tready s_tdata    s_tdata[31:0] value
//                s_tuser                      s_tuser cmd (0 hex, 1 decimal)
// output    out  m_tvalid m_tready m_tdata    m_tdata[6:0] ascii_char, [7] zero
//                m_tlast                      m_tlast marks the final digit
//
// One value at a time. A decimal value is loaded and then converted by the
// shift-add BCD converter; hex skips the shift-add conversion. Leading zeros
// are then dropped, keeping at least one digit, and each character is emitted
// once the output register is free. The output register lets the last character
// wait while the next value is taken. Reset is synchronous and empties both
// channels.
`default_nettype none
`include "binary_to_ascii_hex_dec_macros.svh"

module binary_to_ascii_hex_dec
  import b2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] ascii_char, [7] zero fill
  output logic        m_tlast
);

  b2a_cmd_t             ctl_cmd;
  b2a_status_t          dp_status;
  logic [CharWidth-1:0] char_q;

  // Controller.
  b2a_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_radix (s_tuser),
    .in_ready (s_tready),
    .status   (dp_status),
    .cmd      (ctl_cmd)
  );

  // Datapath.
  b2a_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl_cmd),
    .in_radix  (s_tuser),
    .in_value  (s_tdata),
    .status    (dp_status),
    .out_char  (char_q),
    .out_last  (m_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  assign m_tdata = {1'b0, char_q};

  // Checks on the converter's own control.
  `B2A_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "input ready right after a transfer")
  `B2A_ASSERT_NOW(a_skip_keeps_digit, clk, rst, ctl_cmd.skip, !dp_status.last_digit, "final digit skipped")
  `B2A_ASSERT_NOW(a_emit_when_free, clk, rst, ctl_cmd.emit, !m_tvalid || m_tready, "character overwritten before transfer")
  `B2A_ASSERT_NOW(a_char_range, clk, rst, m_tvalid, (char_q >= 7'd48 && char_q <= 7'd57) || (char_q >= 7'd65 && char_q <= 7'd70), "character outside digit set")

endmodule

`default_nettype wire

[src/b2a_ctrl.sv]
// Controller state machine for the binary to ASCII converter.
// Depends on b2a_pkg; drives commands to b2a_datapath and reads its status.
`default_nettype none

module b2a_ctrl
  import b2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_radix,
  output logic        in_ready,
  input  b2a_status_t status,
  output b2a_cmd_t    cmd
);

  b2a_state_t state;
  b2a_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (in_radix == CMD_DEC) ? ST_CONV : ST_SKIP;
        end
      end
      ST_CONV: begin
        cmd.dabble = 1'b1;
        if (status.conv_done) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, keeping at least one digit.
        if (status.lead_zero && !status.last_digit) begin
          cmd.skip = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_digit) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/b2a_datapath.sv]
// Datapath for the binary to ASCII converter: shift-add BCD conversion,
// digit shift register and the output character register. Depends on b2a_pkg.
`default_nettype none

module b2a_datapath
  import b2a_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  b2a_cmd_t              cmd,
  input  logic                  in_radix,
  input  logic [ValueWidth-1:0] in_value,
  output b2a_status_t           status,
  output logic [CharWidth-1:0]  out_char,
  output logic                  out_last,
  output logic                  out_valid,
  input  logic                  out_ready
);

  logic [ValueWidth-1:0] bin;
  logic [DigitRegW-1:0]  dig;
  logic [StepCountW-1:0] step;
  logic [RemainW-1:0]    remaining;
  logic [DigitRegW-1:0]  dig_adj;

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      if (dig[4*i +: 4] >= 4'd5) begin
        dig_adj[4*i +: 4] = dig[4*i +: 4] + 4'd3;
      end else begin
        dig_adj[4*i +: 4] = dig[4*i +: 4];
      end
    end
  end

  // Binary, digit and counter registers. The current top digit is dig[top nibble].
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      step <= '0;
      if (in_radix == CMD_DEC) begin
        bin       <= in_value;
        dig       <= '0;
        remaining <= RemainW'(DecDigits);
      end else begin
        bin       <= in_value;
        dig       <= {in_value, {(DigitRegW - ValueWidth){1'b0}}};
        remaining <= RemainW'(HexDigits);
      end
    end else if (cmd.dabble) begin
      bin  <= {bin[ValueWidth-2:0], 1'b0};
      dig  <= {dig_adj[DigitRegW-2:0], bin[ValueWidth-1]};
      step <= step + StepCountW'(1);
    end else if (cmd.skip || cmd.emit) begin
      dig       <= {dig[DigitRegW-5:0], 4'h0};
      remaining <= remaining - RemainW'(1);
    end
  end

  // Output character register; a new character may load as the old one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char <= digit_to_ascii(dig[DigitRegW-1 -: 4]);
      out_last <= (remaining == RemainW'(1));
    end
  end

  // Status to the controller.
  always_comb begin
    status.conv_done  = (step == {StepCountW{1'b1}});
    status.lead_zero  = (dig[DigitRegW-1 -: 4] == 4'h0);
    status.last_digit = (remaining == RemainW'(1));
    status.out_free   = !out_valid || out_ready;
  end

endmodule

`default_nettype wire
